// ----- design/mlpq_pkg.sv -----
// ---------------------------------------------------------------------------
// mlpq_pkg: shared types and codes for the multilevel priority ready queue
// Holds the request kind codes and the sequencer state type.
// ---------------------------------------------------------------------------
package mlpq_pkg;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_LINK,
    ST_ENQ_TERM,
    ST_DEQ_SCAN,
    ST_DEQ_READ,
    ST_DEQ_UPD
  } state_t;

endpackage

// ----- design/multilevel_priority_ready_queue_top.sv -----
// ---------------------------------------------------------------------------
// multilevel_priority_ready_queue_top: thread ready queue with priority levels
// Each level is a FIFO kept as head/tail pointers over a shared next table.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall): kind selects enqueue or dequeue;
//   thread_id and priority_req matter for enqueue only. req_stall is high
//   while an item is in work, so one item is handled at a time.
//   Response channel (rsp_valid/rsp_stall): one transfer per request. found
//   is 1 when a dequeue returned chosen_thread, else both are 0.
// Sequencing:
//   Enqueue passes through link, terminate and output steps.
//   Dequeue scans the levels one level per cycle from the highest down, then
//   does one next-table read and a head update before the output.
// Reset:
//   All levels come up empty. The next table is not cleared; an entry is
//   only read after it was written.
// Stall:
//   A finished result waits in the output register; the sequencer holds in
//   its last step until the output register is free.
module multilevel_priority_ready_queue_top #(
  parameter int THREADS = 64,
  parameter int LEVELS  = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       kind,
  input  logic [$clog2(THREADS)-1:0] thread_id,
  input  logic [$clog2(LEVELS)-1:0]  priority_req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       found,
  output logic [$clog2(THREADS)-1:0] chosen_thread
);
  import mlpq_pkg::*;

  localparam int TIDW  = $clog2(THREADS);
  localparam int PRIOW = $clog2(LEVELS);
  localparam logic [TIDW:0]    END_MARK = THREADS[TIDW:0];
  localparam logic [PRIOW:0]   LEVEL_LIM = LEVELS[PRIOW:0];
  localparam logic [PRIOW-1:0] TOP_LEVEL = PRIOW'(LEVELS - 1);

  state_t state, state_next;

  logic                 level_nonempty [LEVELS];
  logic [TIDW-1:0]      level_head     [LEVELS];
  logic [TIDW-1:0]      level_tail     [LEVELS];
  logic [TIDW:0]        next_mem       [THREADS];

  logic [PRIOW-1:0]     cur_lvl;
  logic [TIDW-1:0]      cur_tid;
  logic                 op_ok;
  logic [TIDW:0]        rd_data;

  logic                 rsp_free;
  logic                 mem_we;
  logic [TIDW-1:0]      mem_waddr;
  logic [TIDW:0]        mem_wdata;
  logic                 mem_re;
  logic                 rsp_load;
  logic                 rsp_found_next;
  logic                 lvl_ne;
  logic                 req_xfer;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign lvl_ne    = level_nonempty[cur_lvl];
  assign req_stall = (state != ST_IDLE);
  assign req_xfer  = req_valid && !req_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (kind == KIND_DEQ) ? ST_DEQ_SCAN : ST_ENQ_LINK;
        end
      end
      ST_ENQ_LINK: state_next = ST_ENQ_TERM;
      ST_ENQ_TERM: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      ST_DEQ_SCAN: begin
        if (lvl_ne) begin
          state_next = ST_DEQ_READ;
        end else if (cur_lvl == '0 && rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DEQ_READ: state_next = ST_DEQ_UPD;
      ST_DEQ_UPD: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = cur_tid;
    mem_wdata      = END_MARK;
    mem_re         = 1'b0;
    rsp_load       = 1'b0;
    rsp_found_next = 1'b0;
    case (state)
      ST_ENQ_LINK: begin
        // append behind the current tail
        mem_we    = op_ok && lvl_ne;
        mem_waddr = level_tail[cur_lvl];
        mem_wdata = {1'b0, cur_tid};
      end
      ST_ENQ_TERM: begin
        // terminate the list at the new tail
        mem_we   = op_ok && rsp_free;
        rsp_load = rsp_free;
      end
      ST_DEQ_SCAN: begin
        rsp_load = !lvl_ne && cur_lvl == '0 && rsp_free;
      end
      ST_DEQ_READ: begin
        mem_re = 1'b1;
      end
      ST_DEQ_UPD: begin
        rsp_load       = rsp_free;
        rsp_found_next = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // next-pointer table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= next_mem[level_head[cur_lvl]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item registers and level scan
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cur_tid <= thread_id;
      op_ok   <= ({1'b0, priority_req} < LEVEL_LIM) && ({1'b0, thread_id} < END_MARK);
      cur_lvl <= (kind == KIND_DEQ) ? TOP_LEVEL : priority_req;
    end else if (state == ST_DEQ_SCAN && !lvl_ne && cur_lvl != '0) begin
      cur_lvl <= cur_lvl - 1'b1;
    end
  end

  // level pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_nonempty[i] <= 1'b0;
        level_head[i]     <= '0;
        level_tail[i]     <= '0;
      end
    end else begin
      if (state == ST_ENQ_LINK && op_ok) begin
        if (!lvl_ne) begin
          level_head[cur_lvl]     <= cur_tid;
          level_nonempty[cur_lvl] <= 1'b1;
        end
        level_tail[cur_lvl] <= cur_tid;
      end
      if (state == ST_DEQ_UPD && rsp_free) begin
        if (rd_data >= END_MARK) begin
          // list drained: drop the level
          level_nonempty[cur_lvl] <= 1'b0;
          level_head[cur_lvl]     <= '0;
          level_tail[cur_lvl]     <= '0;
        end else begin
          level_head[cur_lvl] <= rd_data[TIDW-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      found         <= rsp_found_next;
      chosen_thread <= rsp_found_next ? level_head[cur_lvl] : '0;
    end
  end

endmodule

// ----- verif/mlpq_checker.sv -----
// ---------------------------------------------------------------------------
// mlpq_checker: scoreboard for the multilevel priority ready queue
// Watches both channels, keeps its own copy of the level lists and the
// next-pointer table, and compares each response with the oldest pick due.
// ---------------------------------------------------------------------------
module mlpq_checker #(
  parameter int THREADS = 64,
  parameter int LEVELS  = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  logic                       kind,
  input  logic [$clog2(THREADS)-1:0] thread_id,
  input  logic [$clog2(LEVELS)-1:0]  priority_req,
  input  logic                       rsp_valid,
  input  logic                       rsp_stall,
  input  logic                       found,
  input  logic [$clog2(THREADS)-1:0] chosen_thread,
  output int                         fail_count,
  output int                         pending,
  output int                         handed_out,
  output int                         empty_pulls
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlpq_pkg::*;

  localparam int TW = $clog2(THREADS);
  localparam int LW = $clog2(LEVELS);
  localparam logic [TW:0] LIST_END = THREADS[TW:0];

  typedef struct packed {
    logic          found;
    logic [TW-1:0] chosen;
  } pick_t;

  logic          lvl_busy [LEVELS];
  logic [TW-1:0] lvl_head [LEVELS];
  logic [TW-1:0] lvl_tail [LEVELS];
  logic [TW:0]   link_next [THREADS];
  pick_t         picks_due [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    handed_out  = 0;
    empty_pulls = 0;
  end

  task automatic report_mismatch(input string what, input logic [TW:0] got,
                                 input logic [TW:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Append a thread to its level, or pull the head of the highest busy level.
  function automatic pick_t link_or_pick(input logic k, input logic [TW-1:0] tid,
                                         input logic [LW-1:0] lvl);
    pick_t       res;
    logic [TW-1:0] h;
    logic [TW:0] nx;
    res = '0;
    if (k == KIND_ENQ) begin
      if (lvl < LEVELS && tid < THREADS) begin
        if (!lvl_busy[lvl]) begin
          lvl_head[lvl] = tid;
          lvl_busy[lvl] = 1'b1;
        end else if (lvl_tail[lvl] < THREADS) begin
          link_next[lvl_tail[lvl]] = {1'b0, tid};
        end
        lvl_tail[lvl] = tid;
        link_next[tid] = LIST_END;
      end
    end else begin
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
        if (lvl_busy[lv] && !res.found) begin
          h  = lvl_head[lv];
          nx = (h < THREADS) ? link_next[h] : LIST_END;
          if (nx >= THREADS) begin
            lvl_busy[lv] = 1'b0;
            lvl_head[lv] = '0;
            lvl_tail[lv] = '0;
          end else begin
            lvl_head[lv] = nx[TW-1:0];
          end
          res.found  = 1'b1;
          res.chosen = h;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        lvl_busy[i] = 1'b0;
        lvl_head[i] = '0;
        lvl_tail[i] = '0;
      end
      for (int i = 0; i < THREADS; i++) link_next[i] = '0;
      picks_due.delete();
    end else begin
      // check the response before queuing this edge's request
      if (rsp_valid && !rsp_stall) begin
        if (picks_due.size() == 0) begin
          report_mismatch("response with nothing pending", {1'b0, chosen_thread}, '0);
        end else begin
          want = picks_due.pop_front();
          if (found !== want.found)
            report_mismatch("found", {{TW{1'b0}}, found}, {{TW{1'b0}}, want.found});
          if (chosen_thread !== want.chosen)
            report_mismatch("chosen_thread", {1'b0, chosen_thread}, {1'b0, want.chosen});
          if (want.found) handed_out++;
        end
      end
      if (req_valid && !req_stall) begin
        want = link_or_pick(kind, thread_id, priority_req);
        picks_due.push_back(want);
        if (kind == KIND_DEQ && !want.found) empty_pulls++;
      end
    end
    pending = picks_due.size();
  end

endmodule

// ----- verif/tb_multilevel_priority_ready_queue_top.sv -----
// ---------------------------------------------------------------------------
// tb_multilevel_priority_ready_queue_top: stimulus for the ready queue
// Drives directed and random enqueue/dequeue traffic under several idle and
// stall mixes, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_multilevel_priority_ready_queue_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mlpq_pkg::*;

  localparam int THREADS     = 64;
  localparam int LEVELS      = 10;
  localparam int TW          = $clog2(THREADS);
  localparam int LW          = $clog2(LEVELS);
  localparam int CYCLE_LIMIT = 200000;

  logic          clk          = 1'b0;
  logic          rst          = 1'b1;
  logic          req_valid    = 1'b0;
  logic          req_stall;
  logic          kind         = KIND_ENQ;
  logic [TW-1:0] thread_id    = '0;
  logic [LW-1:0] priority_req = '0;
  logic          rsp_valid;
  logic          rsp_stall    = 1'b0;
  logic          found;
  logic [TW-1:0] chosen_thread;

  int fail_count;
  int pending;
  int handed_out;
  int empty_pulls;
  int cycles        = 0;
  int sent          = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_ask      = 0;
  int hold_left     = 0;

  multilevel_priority_ready_queue_top #(
    .THREADS(THREADS),
    .LEVELS (LEVELS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .thread_id    (thread_id),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .chosen_thread(chosen_thread)
  );

  mlpq_checker #(
    .THREADS(THREADS),
    .LEVELS (LEVELS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .thread_id    (thread_id),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .chosen_thread(chosen_thread),
    .fail_count   (fail_count),
    .pending      (pending),
    .handed_out   (handed_out),
    .empty_pulls  (empty_pulls)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still due", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response stall: a requested long hold first, then random stalling.
  always @(negedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic k, input logic [TW-1:0] tid,
                           input logic [LW-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid    <= 1'b0;
      thread_id    <= TW'($urandom_range(THREADS - 1));
      priority_req <= LW'($urandom_range((1 << LW) - 1));
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    kind         <= k;
    thread_id    <= tid;
    priority_req <= lvl;
    do @(posedge clk); while (req_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_pull();
    send_item(KIND_DEQ, TW'($urandom_range(THREADS - 1)),
              LW'($urandom_range((1 << LW) - 1)));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly live traffic on a few hot levels; out-of-range levels are not counted.
  task automatic random_traffic(input int count);
    int done;
    int roll;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        send_item(KIND_ENQ, TW'($urandom_range(THREADS - 1)),
                  LW'($urandom_range((1 << LW) - 1, LEVELS)));
      end else begin
        if (roll < 56) begin
          if ($urandom_range(1))
            send_item(KIND_ENQ, TW'($urandom_range(THREADS - 1)),
                      LW'($urandom_range(LEVELS - 1)));
          else
            send_item(KIND_ENQ, TW'($urandom_range(THREADS - 1)),
                      LW'($urandom_range(3) * 3));
        end else begin
          send_pull();
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pull, range edges, ignored levels, repeated and shared threads
    send_pull();
    send_item(KIND_ENQ, 0, 0);
    send_item(KIND_ENQ, 63, 9);
    send_item(KIND_ENQ, 42, 10);
    send_item(KIND_ENQ, 21, 15);
    send_item(KIND_ENQ, 21, 5);
    send_item(KIND_ENQ, 42, 5);
    send_item(KIND_ENQ, 7, 3);
    send_item(KIND_ENQ, 7, 3);
    send_item(KIND_ENQ, 5, 2);
    send_item(KIND_ENQ, 5, 4);
    send_item(KIND_ENQ, 62, 2);
    send_item(KIND_DEQ, 63, 15);
    repeat (10) send_pull();
    wait_drained();

    // no idling, with a long response hold that backs up the request side
    random_traffic(70);
    hold_ask = 150;
    random_traffic(20);
    wait_drained();
    random_traffic(50);
    wait_drained();

    send_idle_pct = 74;
    stall_pct     = 0;
    random_traffic(135);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 74;
    random_traffic(135);
    wait_drained();

    send_idle_pct = 29;
    stall_pct     = 29;
    random_traffic(135);
    wait_drained();

    stall_pct = 0;
    repeat (LEVELS + 8) @(negedge clk);

    $display("Sent %0d requests over four idle/stall mixes; %0d threads came back out.",
             sent, handed_out);
    $display("Covered %0d empty pulls, ignored levels, repeated threads and a backed-up queue.",
             empty_pulls);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
